FILE: sv/gcca_pkg.sv
// Shared widths, angle constants and elaboration-time CORDIC table functions.
package gcca_pkg;

  localparam int XW = 36;
  localparam int SW = 62;
  localparam int SQ_STEPS = 31;
  localparam logic [63:0] QUARTER_T = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_T = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90F_DAA2_2168_C235;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] frac_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    logic carry;
    q = '0;
    r = n;
    for (int k = 0; k < 64; k++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] w;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    w = v;
    for (int k = 0; k < 32; k++) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] atan_turn(input int i);
    logic [63:0] sum;
    logic [63:0] t;
    int e;
    sum = '0;
    if (i == 0) begin
      return 64'h2000_0000_0000_0000;
    end
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if ((k % 2) == 0) begin
          sum = sum + t;
        end else begin
          sum = sum - t;
        end
      end
    end
    return frac_div(sum >> 1, TWO_PI_Q61);
  endfunction

  function automatic logic [63:0] cordic_gain(input int steps);
    logic [63:0] p;
    logic [63:0] k32;
    p = 64'd1 << 60;
    for (int i = 0; i < 64; i++) begin
      if (i < steps && 2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    k32 = isqrt64(frac_div(64'd1 << 60, p));
    return (k32 + 64'd2) >> 2;
  endfunction

endpackage

FILE: sv/gcca_rot_cell.sv
// One rotation-mode CORDIC cell that turns a vector by the step angle toward the target.
module gcca_rot_cell import gcca_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [63:0]          th_i,
  input  logic                 flip_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [63:0]          th_o,
  output logic                 flip_o
);

  localparam logic [63:0] ATAN = atan_turn(STEP);

  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic [63:0] th_d, th_q;
  logic flip_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!th_i[63]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      th_d = th_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      th_d = th_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      th_q <= th_d;
      flip_q <= flip_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign th_o = th_q;
  assign flip_o = flip_q;

endmodule

FILE: sv/gcca_sqrt_cell.sv
// One digit step of the bit-pair integer square root.
module gcca_sqrt_cell import gcca_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] v_i,
  input  logic [SW-1:0] r_i,
  output logic [SW-1:0] v_o,
  output logic [SW-1:0] r_o
);

  localparam logic [SW-1:0] BIT = SW'(1) << (60 - 2 * STEP);

  logic [SW-1:0] v_d, r_d, v_q, r_q, trial;

  always_comb begin
    trial = r_i + BIT;
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + BIT;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

FILE: sv/gcca_vec_cell.sv
// One vectoring-mode CORDIC cell that drives y toward zero and sums the step angles.
module gcca_vec_cell import gcca_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [63:0]          acc_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [63:0]          acc_o
);

  localparam logic [63:0] ATAN = atan_turn(STEP);

  logic signed [XW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic [63:0] acc_d, acc_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      acc_d = acc_i + ATAN;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      acc_d = acc_i - ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      acc_q <= acc_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign acc_o = acc_q;

endmodule

FILE: sv/great_circle_central_angle.sv
// Top level: haversine central angle between two points as a pipeline of CORDIC and root cells.
// The block takes one point pair per clock while in_stall_o is low and returns each
// central angle at the end of the chain of cells: input and range-fold registers,
// CORDIC_STEPS rotation cells in four lanes, three multiply registers and a saturation
// register, 31 square-root cells in two lanes, CORDIC_STEPS vectoring cells, and the
// output register. A two-entry output buffer lets the block keep taking items while one
// result waits to be taken.
module great_circle_central_angle import gcca_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STEPS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] lat_a_i,
  input  logic [31:0] lon_a_i,
  input  logic [31:0] lat_b_i,
  input  logic [31:0] lon_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] central_angle_o
);

  localparam int TS = 64 - ANGLE_BITS;
  localparam int N = CORDIC_STEPS;
  localparam int L = 2 * N + 6 + SQ_STEPS;
  localparam int ZM = N + 5;
  localparam logic signed [XW-1:0] GAIN = XW'(cordic_gain(CORDIC_STEPS));
  localparam logic [63:0] RND = 64'd1 << (TS - 1);

  logic en;
  logic [L-1:0] vld_q;

  logic [63:0] ang_q [4];
  logic [63:0] ang_in [4];

  logic signed [XW-1:0] rx [4][N+1];
  logic signed [XW-1:0] ry [4][N+1];
  logic [63:0] rth [4][N+1];
  logic rfl [4][N+1];

  logic signed [XW-1:0] px_q [4];
  logic [63:0] pth_q [4];
  logic pfl_q [4];

  logic signed [31:0] trig [4];
  logic signed [XW-1:0] cl [4];
  logic signed [63:0] m1a, m1b, m2, m3;
  logic signed [31:0] p1_q, p2_q, ca_q, cb_q, p1b_q, cbb_q, p3_q, p1c_q, p4_q;
  logic signed [32:0] zsum;
  logic [30:0] zs;
  logic [SW-1:0] vz_q, vw_q;

  logic [SW-1:0] sv [2][SQ_STEPS+1];
  logic [SW-1:0] sr [2][SQ_STEPS+1];

  logic signed [XW-1:0] vx [N+1];
  logic signed [XW-1:0] vy [N+1];
  logic [63:0] vacc [N+1];

  logic [63:0] ang_a, ang_t, ang_r;
  logic [31:0] res;

  logic out_valid_q, skid_valid_q;
  logic [31:0] out_q, skid_q;

  assign en = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  always_comb begin
    logic [63:0] la, lb, loa, lob, dlat, dlon;
    la = {{32{lat_a_i[31]}}, lat_a_i} << TS;
    lb = {{32{lat_b_i[31]}}, lat_b_i} << TS;
    loa = {{32{lon_a_i[31]}}, lon_a_i} << TS;
    lob = {{32{lon_b_i[31]}}, lon_b_i} << TS;
    dlat = lb - la;
    dlon = lob - loa;
    ang_in[0] = {dlat[63], dlat[63:1]};
    ang_in[1] = {dlon[63], dlon[63:1]};
    ang_in[2] = la;
    ang_in[3] = lb;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        ang_q[l] <= ang_in[l];
        if (ang_q[l] > QUARTER_T && ang_q[l] < (64'd0 - QUARTER_T)) begin
          pth_q[l] <= ang_q[l] - HALF_T;
          pfl_q[l] <= 1'b1;
        end else begin
          pth_q[l] <= ang_q[l];
          pfl_q[l] <= 1'b0;
        end
        px_q[l] <= GAIN;
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign rx[l][0] = px_q[l];
    assign ry[l][0] = '0;
    assign rth[l][0] = pth_q[l];
    assign rfl[l][0] = pfl_q[l];
    for (genvar j = 0; j < N; j++) begin : g_rot
      gcca_rot_cell #(.STEP(j)) u_rot (
        .clk_i  (clk_i),
        .en_i   (en),
        .x_i    (rx[l][j]),
        .y_i    (ry[l][j]),
        .th_i   (rth[l][j]),
        .flip_i (rfl[l][j]),
        .x_o    (rx[l][j+1]),
        .y_o    (ry[l][j+1]),
        .th_o   (rth[l][j+1]),
        .flip_o (rfl[l][j+1])
      );
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (l < 2) begin
        cl[l] = ry[l][N];
      end else begin
        cl[l] = rx[l][N];
      end
      if (cl[l] > XW'(ONE_Q30)) begin
        cl[l] = XW'(ONE_Q30);
      end else if (cl[l] < -XW'(ONE_Q30)) begin
        cl[l] = -XW'(ONE_Q30);
      end
      if (rfl[l][N]) begin
        cl[l] = -cl[l];
      end
      trig[l] = 32'(cl[l]);
    end
    m1a = 64'(trig[0]) * 64'(trig[0]) + 64'sd536870912;
    m1b = 64'(trig[1]) * 64'(trig[1]) + 64'sd536870912;
    m2 = 64'(p2_q) * 64'(ca_q) + 64'sd536870912;
    m3 = 64'(p3_q) * 64'(cbb_q) + 64'sd536870912;
    zsum = 33'(p1c_q) + 33'(p4_q);
    if (zsum < 0) begin
      zs = '0;
    end else if (zsum > 33'(ONE_Q30)) begin
      zs = 31'(ONE_Q30);
    end else begin
      zs = zsum[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= 32'(m1a >>> 30);
      p2_q <= 32'(m1b >>> 30);
      ca_q <= trig[2];
      cb_q <= trig[3];
      p1b_q <= p1_q;
      cbb_q <= cb_q;
      p3_q <= 32'(m2 >>> 30);
      p1c_q <= p1b_q;
      p4_q <= 32'(m3 >>> 30);
      vz_q <= SW'(zs) << 30;
      vw_q <= SW'(31'(ONE_Q30) - zs) << 30;
    end
  end

  assign sv[0][0] = vz_q;
  assign sv[1][0] = vw_q;
  assign sr[0][0] = '0;
  assign sr[1][0] = '0;

  for (genvar q = 0; q < 2; q++) begin : g_root
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      gcca_sqrt_cell #(.STEP(k)) u_sq (
        .clk_i (clk_i),
        .en_i  (en),
        .v_i   (sv[q][k]),
        .r_i   (sr[q][k]),
        .v_o   (sv[q][k+1]),
        .r_o   (sr[q][k+1])
      );
    end
  end

  assign vy[0] = XW'(sr[0][SQ_STEPS]);
  assign vx[0] = XW'(sr[1][SQ_STEPS]);
  assign vacc[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_vec
    gcca_vec_cell #(.STEP(j)) u_vec (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[j]),
      .y_i   (vy[j]),
      .acc_i (vacc[j]),
      .x_o   (vx[j+1]),
      .y_o   (vy[j+1]),
      .acc_o (vacc[j+1])
    );
  end

  always_comb begin
    ang_a = vacc[N][63] ? 64'd0 : vacc[N];
    if (ang_a > QUARTER_T) begin
      ang_a = QUARTER_T;
    end
    ang_t = ang_a << 1;
    ang_r = (ang_t + RND) >> TS;
    res = ang_r[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= vld_q[L-1];
    end else if (vld_q[L-1]) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign central_angle_o = out_q;

endmodule

FILE: tb/great_circle_central_angle_chk.sv
// Checker: watches both channels, predicts each central angle and compares results.
module great_circle_central_angle_chk #(
  parameter int ANGLE_BITS = 32,
  parameter int CORDIC_STEPS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] lat_a_i,
  input  logic [31:0] lon_a_i,
  input  logic [31:0] lat_b_i,
  input  logic [31:0] lon_b_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] central_angle_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [63:0] QUARTER = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TWO_PI = 64'hC90F_DAA2_2168_C235;
  localparam longint UNIT = 64'sd1 << 30;
  localparam int TSHIFT = 64 - ANGLE_BITS;

  logic [63:0] arc_step[CORDIC_STEPS];
  longint gain;
  logic [31:0] angle_q[$];

  function automatic logic [63:0] turn_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    logic carry;
    q = '0;
    r = n;
    for (int k = 0; k < 64; k++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v && b != 0) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint limit_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void rotate(input logic [63:0] th, output longint s, output longint c);
    longint x;
    longint y;
    longint dx;
    longint dy;
    logic flip;
    x = gain;
    y = 0;
    flip = 1'b0;
    if (th > QUARTER && th < (64'd0 - QUARTER)) begin
      th = th - HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (th[63] == 1'b0) begin
        x = x - dx;
        y = y + dy;
        th = th - arc_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        th = th + arc_step[i];
      end
    end
    x = limit_unit(x);
    y = limit_unit(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [63:0] to_turn(logic [31:0] f);
    longint v;
    v = longint'(signed'(f));
    return 64'(v) << TSHIFT;
  endfunction

  function automatic logic [31:0] central_angle(logic [31:0] la_f, logic [31:0] loa_f,
                                                logic [31:0] lb_f, logic [31:0] lob_f);
    logic [63:0] la;
    logic [63:0] lb;
    logic [63:0] hlat;
    logic [63:0] hlon;
    logic [63:0] acc;
    logic [63:0] th;
    longint s_lat;
    longint s_lon;
    longint c_a;
    longint c_b;
    longint unused;
    longint z;
    longint y;
    longint x;
    longint dx;
    longint dy;
    la = to_turn(la_f);
    lb = to_turn(lb_f);
    hlat = lb - la;
    hlat = (hlat >> 1) | (hlat & HALF);
    hlon = to_turn(lob_f) - to_turn(loa_f);
    hlon = (hlon >> 1) | (hlon & HALF);
    rotate(hlat, s_lat, unused);
    rotate(hlon, s_lon, unused);
    rotate(la, unused, c_a);
    rotate(lb, unused, c_b);
    z = qmul(s_lat, s_lat) + qmul(qmul(qmul(s_lon, s_lon), c_a), c_b);
    if (z < 0) z = 0;
    if (z > UNIT) z = UNIT;
    y = longint'(root_floor(64'(z) << 30));
    x = longint'(root_floor(64'(UNIT - z) << 30));
    acc = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + arc_step[i];
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - arc_step[i];
      end
    end
    if (acc[63]) acc = '0;
    if (acc > QUARTER) acc = QUARTER;
    th = acc << 1;
    th = (th + (64'd1 << (TSHIFT - 1))) >> TSHIFT;
    return th[31:0];
  endfunction

  initial begin
    logic [63:0] p;
    logic [63:0] sum;
    int e;
    p = 64'd1 << 60;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        arc_step[i] = 64'h2000_0000_0000_0000;
      end else begin
        sum = '0;
        for (int k = 0; k < 40; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            if (k % 2 == 0) sum = sum + (64'd1 << (62 - e)) / 64'(2 * k + 1);
            else sum = sum - (64'd1 << (62 - e)) / 64'(2 * k + 1);
          end
        end
        arc_step[i] = turn_div(sum >> 1, TWO_PI);
      end
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    gain = longint'((root_floor(turn_div(64'd1 << 60, p)) + 64'd2) >> 2);
  end

  assign pending_o = angle_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      errors_o <= 0;
      checked_o <= 0;
      angle_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        angle_q.push_back(central_angle(lat_a_i, lon_a_i, lat_b_i, lon_b_i));
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected central_angle %0d", $time, central_angle_i);
          errors_o <= errors_o + 1;
        end else begin
          want = angle_q.pop_front();
          if (want !== central_angle_i) begin
            $display("%0t: central_angle expected %0d actual %0d", $time, want,
                     central_angle_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/great_circle_central_angle_tb.sv
// Testbench top: drives point pairs with random idling and gives the verdict.
module great_circle_central_angle_tb;

  localparam int NUM_RANDOM = 700;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [31:0] lat_a_i;
  logic [31:0] lon_a_i;
  logic [31:0] lat_b_i;
  logic [31:0] lon_b_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [31:0] central_angle_o;
  int errors;
  int pending;
  int checked;
  int cycles;
  int sent;
  logic calm;

  great_circle_central_angle uut (.*);

  great_circle_central_angle_chk chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .lat_a_i, .lon_a_i, .lat_b_i, .lon_b_i,
    .out_valid_i(out_valid_o), .out_stall_i, .central_angle_i(central_angle_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls in random bursts until the final stretch.
  always @(posedge clk_i) begin
    int n;
    if (rst_ni && !calm && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 19);
      out_stall_i <= 1'b1;
      repeat (n) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [31:0] rand_lat();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
      1: return $urandom();
      default: return 32'($urandom_range(0, 32'h7FFF_FFFF)) - 32'h4000_0000;
    endcase
  endfunction

  task automatic send(input logic [31:0] la, input logic [31:0] loa,
                      input logic [31:0] lb, input logic [31:0] lob);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    lat_a_i <= la;
    lon_a_i <= loa;
    lat_b_i <= lb;
    lon_b_i <= lob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    logic [31:0] la;
    logic [31:0] lo;
    cycles = 0;
    sent = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    lat_a_i = '0;
    lon_a_i = '0;
    lat_b_i = '0;
    lon_b_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Coincident, antipodal, pole, extreme and wrapped cases.
    send(0, 0, 0, 0);
    send(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
    send(0, 0, 0, 32'h8000_0000);
    send(32'h4000_0000, 0, 32'hC000_0000, 0);
    send(32'h4000_0000, 32'h1111_1111, 32'h4000_0000, 32'h9999_9999);
    send(32'hC000_0000, 32'h8000_0000, 32'h4000_0000, 32'h7FFF_FFFF);
    send(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send(0, 32'h7FFF_FFFF, 0, 32'h8000_0000);
    send(32'h2000_0000, 32'hFFFF_FFFF, 32'hE000_0000, 32'h0000_0001);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'h6000_0000, 0, 32'hA000_0000, 32'h4000_0000);
    send(32'h1000_0000, 32'h2000_0000, 32'hF000_0000, 32'hA000_0000);
    send(0, 0, 1, 1);
    send(32'h3FFF_FFFF, 0, 32'hC000_0001, 32'h8000_0000);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 100) calm = 1'b1;
      la = rand_lat();
      lo = $urandom();
      case ($urandom_range(0, 5))
        0: send(la, lo, la, lo);
        1: send(la, lo, -la, lo ^ 32'h8000_0000);
        2: send(la, lo, la + 32'($urandom_range(0, 255)) - 128,
                lo + 32'($urandom_range(0, 255)) - 128);
        default: send(la, lo, rand_lat(), $urandom());
      endcase
    end
    in_valid_i <= 1'b0;
    calm = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("Sent %0d point pairs (extremes, poles, coincident, antipodal, wrapped);",
             sent);
    $display("checked %0d central angles under random idling on both sides.", checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
